@@ rtl/histogram_keyframe_gate_defines.svh @@
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef HISTOGRAM_KEYFRAME_GATE_DEFINES_SVH
`define HISTOGRAM_KEYFRAME_GATE_DEFINES_SVH

// Same-cycle implication.
`define HKG_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HKG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hkg_pkg.sv @@
package hkg_pkg;

    localparam int BINS    = 4096;
    localparam int BIN_AW  = $clog2(BINS);
    localparam int CNT_W   = 25;
    localparam int ID_W    = 32;
    localparam int THR_W   = 7;
    localparam int SKIP_W  = 8;
    localparam int TP_W    = CNT_W + THR_W;
    localparam int LHS_W   = CNT_W + 7;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0]  PIXEL_COUNT_RST = CNT_W'(307200);
    localparam logic [THR_W-1:0]  THRESHOLD_RST   = THR_W'(22);
    localparam logic [SKIP_W-1:0] SKIP_FRAMES_RST = SKIP_W'(5);
    localparam logic [TP_W-1:0]   THR_PIX_RST     = TP_W'(307200 * 22);
    localparam logic [CNT_W-1:0]  CNT_MAX         = '1;

    localparam logic [1:0] COUNTDOWN_RST   = 2'd3;
    localparam logic [1:0] COUNTDOWN_SEG   = 2'd2;
    localparam logic [1:0] COUNTDOWN_FORCE = 2'd1;

    typedef enum logic [1:0] {
        REG_PIXEL_COUNT = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_SKIP_FRAMES = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0]  pixel_count;
        logic [THR_W-1:0]  threshold;
        logic [SKIP_W-1:0] skip_frames;
        logic [TP_W-1:0]   thr_pix;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]  frame_id;
        logic             is_candidate;
        logic             is_black;
        logic [CNT_W-1:0] overlap;
    } frame_req_t;

    typedef struct packed {
        logic busy;
        logic ref_sel;
        logic ref_valid;
    } status_t;

endpackage

@@ rtl/hkg_if.sv @@
interface hkg_in_if;
    import hkg_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [ID_W-1:0]  frame_id;
    logic             is_candidate;
    logic             is_black;
    logic [CNT_W-1:0] bin_count;
    logic             last_bin;

    modport source (
        output valid, kind, frame_id, is_candidate, is_black, bin_count, last_bin,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_id, is_candidate, is_black, bin_count, last_bin,
        output ready
    );
endinterface

interface hkg_out_if;
    import hkg_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] out_frame_id;
    logic            keep;
    logic            forced;
    logic            skipped;

    modport source (
        output valid, out_frame_id, keep, forced, skipped,
        input  ready
    );
    modport sink (
        input  valid, out_frame_id, keep, forced, skipped,
        output ready
    );
endinterface

@@ rtl/hkg_cfg.sv @@
module hkg_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hkg_pkg::PADDR_W-1:0] paddr,
    input  logic [hkg_pkg::PDATA_W-1:0] pwdata,
    output logic [hkg_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output hkg_pkg::cfg_t               cfg
);
    import hkg_pkg::*;

    logic [CNT_W-1:0]  pix_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [SKIP_W-1:0] skip_reg;
    logic [TP_W-1:0]   thr_pix_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg     <= PIXEL_COUNT_RST;
            thr_reg     <= THRESHOLD_RST;
            skip_reg    <= SKIP_FRAMES_RST;
            thr_pix_reg <= THR_PIX_RST;
        end
        else
        begin
            if (wr_en)
            begin
                case (idx)
                    REG_PIXEL_COUNT: pix_reg  <= pwdata[CNT_W-1:0];
                    REG_THRESHOLD:   thr_reg  <= pwdata[THR_W-1:0];
                    REG_SKIP_FRAMES: skip_reg <= pwdata[SKIP_W-1:0];
                    default:         ;
                endcase
            end
            // product is registered, so it trails the registers
            thr_pix_reg <= TP_W'(thr_reg) * TP_W'(pix_reg);
        end
    end

    always_comb
    begin
        case (idx)
            REG_PIXEL_COUNT: prdata = PDATA_W'(pix_reg);
            REG_THRESHOLD:   prdata = PDATA_W'(thr_reg);
            REG_SKIP_FRAMES: prdata = PDATA_W'(skip_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.pixel_count = pix_reg;
    assign cfg.threshold   = thr_reg;
    assign cfg.skip_frames = skip_reg;
    assign cfg.thr_pix     = thr_pix_reg;

endmodule

@@ rtl/hkg_bank.sv @@
module hkg_bank (
    input  logic                       clk,
    input  logic                       ref_sel,
    input  logic                       wr_en,
    input  logic [hkg_pkg::BIN_AW-1:0] addr,
    input  logic [hkg_pkg::CNT_W-1:0]  wr_data,
    output logic [hkg_pkg::CNT_W-1:0]  rd_data
);
    import hkg_pkg::*;

    logic [CNT_W-1:0] bank_a_reg [BINS];
    logic [CNT_W-1:0] bank_b_reg [BINS];
    logic [CNT_W-1:0] rd_data_reg;

    // read the reference bank, write the other one
    always_ff @(posedge clk)
    begin
        if (wr_en && ref_sel)
            bank_a_reg[addr] <= wr_data;
        if (wr_en && !ref_sel)
            bank_b_reg[addr] <= wr_data;
        rd_data_reg <= ref_sel ? bank_b_reg[addr] : bank_a_reg[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/hkg_accum.sv @@
module hkg_accum (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       bin_acc,
    input  logic [hkg_pkg::ID_W-1:0]   frame_id,
    input  logic                       is_candidate,
    input  logic                       is_black,
    input  logic [hkg_pkg::CNT_W-1:0]  bin_count,
    input  logic                       last_bin,
    input  logic [hkg_pkg::CNT_W-1:0]  rd_data,
    output logic [hkg_pkg::BIN_AW-1:0] addr,
    output hkg_pkg::frame_req_t        req,
    output logic                       req_valid
);
    import hkg_pkg::*;

    logic [BIN_AW-1:0] pos_reg;
    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic [CNT_W-1:0]  s1_bin_reg;
    logic [ID_W-1:0]   s1_id_reg;
    logic              s1_cand_reg;
    logic              s1_black_reg;
    logic [CNT_W-1:0]  overlap_reg;
    frame_req_t        req_reg;
    logic              req_valid_reg;

    logic [CNT_W-1:0]  bin_min;
    logic [CNT_W:0]    sum_wide;
    logic [CNT_W-1:0]  sum_sat;

    assign addr = pos_reg;

    always_comb
    begin
        bin_min  = (s1_bin_reg < rd_data) ? s1_bin_reg : rd_data;
        sum_wide = {1'b0, overlap_reg} + {1'b0, bin_min};
        sum_sat  = sum_wide[CNT_W] ? CNT_MAX : sum_wide[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            overlap_reg   <= '0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= bin_acc;
            req_valid_reg <= s1_valid_reg && s1_last_reg;
            if (bin_acc)
            begin
                s1_last_reg <= last_bin;
                if (last_bin || pos_reg == BIN_AW'(BINS - 1))
                    pos_reg <= '0;
                else
                    pos_reg <= pos_reg + 1'b1;
            end
            if (s1_valid_reg)
                overlap_reg <= s1_last_reg ? '0 : sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bin_acc)
        begin
            s1_bin_reg   <= bin_count;
            s1_id_reg    <= frame_id;
            s1_cand_reg  <= is_candidate;
            s1_black_reg <= is_black;
        end
        if (s1_valid_reg && s1_last_reg)
        begin
            req_reg.frame_id     <= s1_id_reg;
            req_reg.is_candidate <= s1_cand_reg;
            req_reg.is_black     <= s1_black_reg;
            req_reg.overlap      <= sum_sat;
        end
    end

    assign req       = req_reg;
    assign req_valid = req_valid_reg;

endmodule

@@ rtl/hkg_decide.sv @@
module hkg_decide (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hkg_pkg::cfg_t            cfg,
    input  hkg_pkg::frame_req_t      req,
    input  logic                     req_valid,
    input  logic                     last_acc,
    input  logic                     seg_acc,
    input  logic                     out_ready,
    output hkg_pkg::status_t         st,
    output logic                     out_valid,
    output logic [hkg_pkg::ID_W-1:0] out_frame_id,
    output logic                     keep,
    output logic                     forced,
    output logic                     skipped
);
    import hkg_pkg::*;

    logic             busy_reg;
    logic             ref_sel_reg;
    logic             ref_valid_reg;
    logic             prev_black_reg;
    logic [1:0]       countdown_reg;
    logic             s3_valid_reg;
    logic [ID_W-1:0]  s3_id_reg;
    logic             s3_cand_reg;
    logic             s3_black_reg;
    logic             s3_ge_reg;
    logic [LHS_W-1:0] s3_lhs_reg;
    logic             out_valid_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic             out_keep_reg;
    logic             out_forced_reg;
    logic             out_skipped_reg;

    logic [CNT_W-1:0] diff;
    logic [LHS_W-1:0] diff_w;
    logic [LHS_W-1:0] lhs;
    logic             fire;
    logic             in_skip;
    logic             at_skip;
    logic             changed;
    logic             keep_diff;
    logic [1:0]       cd_load;
    logic [1:0]       cd_dec;
    logic [1:0]       countdown_next;
    logic             keep_next;
    logic             forced_next;

    // 100 * (pixels - overlap) as shifts and adds
    always_comb
    begin
        diff   = cfg.pixel_count - req.overlap;
        diff_w = LHS_W'(diff);
        lhs    = (diff_w << 6) + (diff_w << 5) + (diff_w << 2);
    end

    assign fire = s3_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        in_skip   = s3_id_reg < ID_W'(cfg.skip_frames);
        at_skip   = s3_id_reg == ID_W'(cfg.skip_frames);
        if (!ref_valid_reg)
            changed = 1'b1;
        else if (s3_ge_reg)
            changed = 1'b0;
        else
            changed = s3_lhs_reg > LHS_W'(cfg.thr_pix);
        keep_diff = !at_skip && s3_cand_reg && changed && !prev_black_reg;
        cd_load   = at_skip ? COUNTDOWN_RST : countdown_reg;
        cd_dec    = (cd_load != 2'd0) ? cd_load - 2'd1 : 2'd0;

        countdown_next = cd_dec;
        keep_next      = keep_diff;
        forced_next    = 1'b0;
        if (cd_dec == COUNTDOWN_FORCE)
        begin
            if (s3_black_reg)
                countdown_next = COUNTDOWN_SEG;
            else
            begin
                keep_next   = 1'b1;
                forced_next = !keep_diff;
            end
        end
        // skip window only records the black flag
        if (in_skip)
        begin
            countdown_next = countdown_reg;
            keep_next      = 1'b0;
            forced_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            ref_sel_reg    <= 1'b0;
            ref_valid_reg  <= 1'b0;
            prev_black_reg <= 1'b0;
            countdown_reg  <= COUNTDOWN_RST;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_valid)
                s3_valid_reg <= 1'b1;
            else if (fire)
                s3_valid_reg <= 1'b0;

            if (last_acc)
                busy_reg <= 1'b1;
            else if (fire)
                busy_reg <= 1'b0;

            if (seg_acc)
                countdown_reg <= COUNTDOWN_SEG;
            else if (fire)
                countdown_reg <= countdown_next;

            if (fire)
            begin
                prev_black_reg <= s3_black_reg;
                if (keep_next)
                begin
                    ref_sel_reg   <= !ref_sel_reg;
                    ref_valid_reg <= 1'b1;
                end
            end

            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            s3_id_reg    <= req.frame_id;
            s3_cand_reg  <= req.is_candidate;
            s3_black_reg <= req.is_black;
            s3_ge_reg    <= req.overlap >= cfg.pixel_count;
            s3_lhs_reg   <= lhs;
        end
        if (fire)
        begin
            out_id_reg      <= s3_id_reg;
            out_keep_reg    <= keep_next;
            out_forced_reg  <= forced_next;
            out_skipped_reg <= in_skip;
        end
    end

    assign st.busy      = busy_reg;
    assign st.ref_sel   = ref_sel_reg;
    assign st.ref_valid = ref_valid_reg;

    assign out_valid    = out_valid_reg;
    assign out_frame_id = out_id_reg;
    assign keep         = out_keep_reg;
    assign forced       = out_forced_reg;
    assign skipped      = out_skipped_reg;

endmodule

@@ rtl/histogram_keyframe_gate.sv @@
// Keyframe gate by histogram intersection.
// in_ch carries one histogram bin per transaction, in bin order, with the
// frame's id, candidate and black flags; kind=1 marks a segment event instead.
// out_ch carries one decision per frame, issued after the frame's last bin.
// Bins stream at one per cycle while in_ch.ready is high; each bin reads the
// reference bank and writes the other bank, both single-port synchronous RAMs
// with registered reads. After a last bin, in_ch.ready stays low while the
// overlap sum is finished, compared and the bank roles are settled. The
// decision passes the s1, request, s3 and output registers to reach out_ch.
// A waiting result sits in the output register while the next frame's bins
// keep flowing; a further decision holds (and in_ch.ready with it) until
// out_ch takes the earlier one.
// Registers (APB, 4-byte spacing): pixel_count, threshold_hundredths,
// skip_frames. Write them only while idle.
// Reset clears control state: no reference, countdown 3, bank a reference.
// Bank contents are not cleared; the first kept frame fills the reference.
module histogram_keyframe_gate (
    input  logic                        clk,
    input  logic                        rst_n,
    hkg_in_if.sink                      in_ch,
    hkg_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hkg_pkg::PADDR_W-1:0] paddr,
    input  logic [hkg_pkg::PDATA_W-1:0] pwdata,
    output logic [hkg_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import hkg_pkg::*;

    `include "histogram_keyframe_gate_defines.svh"

    cfg_t              cfg;
    status_t           st;
    frame_req_t        req;
    logic              req_valid;
    logic              acc;
    logic              bin_acc;
    logic              seg_acc;
    logic              last_acc;
    logic [BIN_AW-1:0] addr;
    logic [CNT_W-1:0]  rd_data;

    assign in_ch.ready = !st.busy;
    assign acc         = in_ch.valid && in_ch.ready;
    assign bin_acc     = acc && !in_ch.kind;
    assign seg_acc     = acc && in_ch.kind;
    assign last_acc    = bin_acc && in_ch.last_bin;

    hkg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hkg_bank u_bank (
        .clk     (clk),
        .ref_sel (st.ref_sel),
        .wr_en   (bin_acc),
        .addr    (addr),
        .wr_data (in_ch.bin_count),
        .rd_data (rd_data)
    );

    hkg_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .bin_acc      (bin_acc),
        .frame_id     (in_ch.frame_id),
        .is_candidate (in_ch.is_candidate),
        .is_black     (in_ch.is_black),
        .bin_count    (in_ch.bin_count),
        .last_bin     (in_ch.last_bin),
        .rd_data      (rd_data),
        .addr         (addr),
        .req          (req),
        .req_valid    (req_valid)
    );

    hkg_decide u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .req          (req),
        .req_valid    (req_valid),
        .last_acc     (last_acc),
        .seg_acc      (seg_acc),
        .out_ready    (out_ch.ready),
        .st           (st),
        .out_valid    (out_ch.valid),
        .out_frame_id (out_ch.out_frame_id),
        .keep         (out_ch.keep),
        .forced       (out_ch.forced),
        .skipped      (out_ch.skipped)
    );

    `HKG_ASSERT_NEXT(a_last_bin_stalls, last_acc, !in_ch.ready, "input taken right after last bin")
    `HKG_ASSERT_NEXT(a_ref_stays_valid, st.ref_valid, st.ref_valid, "reference lost its valid flag")
    `HKG_ASSERT_NOW(a_forced_keeps, out_ch.valid && out_ch.forced, out_ch.keep, "forced without keep")
    `HKG_ASSERT_NOW(a_skip_no_keep, out_ch.valid && out_ch.skipped, !out_ch.keep && !out_ch.forced, "skipped frame kept")

endmodule
